[src/crlf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CRLF line receiver package
// Shared constants for the line receiver: default sizes, field widths,
// operation codes and the terminator byte codes.
// ----------------------------------------------------------------------------
package crlf_pkg;

   localparam int LINE_LEN_DEFAULT = 64;
   localparam int SLOTS_DEFAULT    = 4;

   localparam int BYTE_W  = 8;
   localparam int SLOT_W  = 2;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 6;

   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   localparam logic [BYTE_W-1:0] CODE_CR = 8'h0d;
   localparam logic [BYTE_W-1:0] CODE_LF = 8'h0a;

endpackage
`default_nettype wire

[src/crlf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CRLF generic RAM
// Single write port, single read port, registered read data with enable.
// ----------------------------------------------------------------------------
module crlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[src/crlf_line_receiver_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CRLF line receiver with line store
// Frames serial bytes into lines ended by CR LF, copies each finished line
// into a ring of line slots and serves single-byte reads of those slots.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake         Word
//  req      in         req_valid/stall   operation, rx_byte, read_slot, read_index
//  rsp      out        rsp_valid/stall   read_data, line_done, cr_seen, byte_count,
//                                        next_slot
//
// A receive or a read word is answered from the output register after the LOAD state;
// a word that completes a line passes through the COPY state first, as the copy
// loop moves one byte per cycle through the buffer's read port into the line store.
// Reset is synchronous and clears the control and status registers only;
// both memories hold undefined data until written and need no clearing pass.
// A stalled result waits in its output register while the next word is taken.
// ----------------------------------------------------------------------------
module crlf_line_receiver_store #(
   parameter int LINE_LEN = crlf_pkg::LINE_LEN_DEFAULT,
   parameter int SLOTS    = crlf_pkg::SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_operation,
   input  wire logic [crlf_pkg::BYTE_W-1:0]   req_rx_byte,
   input  wire logic [crlf_pkg::SLOT_W-1:0]   req_read_slot,
   input  wire logic [crlf_pkg::INDEX_W-1:0]  req_read_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [crlf_pkg::BYTE_W-1:0]   rsp_read_data,
   output logic                               rsp_line_done,
   output logic                               rsp_cr_seen,
   output logic      [crlf_pkg::COUNT_W-1:0]  rsp_byte_count,
   output logic      [crlf_pkg::SLOT_W-1:0]   rsp_next_slot
);

   import crlf_pkg::*;

   localparam int CW  = $clog2(LINE_LEN);
   localparam int SW  = $clog2(SLOTS * LINE_LEN);
   localparam int SLW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_COPY = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic              op_ff, op_in;
   logic              in_range_ff, in_range_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              cr_ff, cr_in;
   logic              done_ff, done_in;
   logic [SLW-1:0]    slot_ff, slot_in;
   logic [SW-1:0]     base_ff, base_in;
   logic [SW-1:0]     copy_base_ff, copy_base_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [CW-1:0]     len_ff, len_in;
   logic              wr_valid_ff, wr_valid_in;
   logic [SW-1:0]     wr_addr_ff, wr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_read_data_ff, rsp_read_data_in;
   logic              rsp_line_done_ff, rsp_line_done_in;
   logic              rsp_cr_seen_ff, rsp_cr_seen_in;
   logic [COUNT_W-1:0] rsp_byte_count_ff, rsp_byte_count_in;
   logic [SLOT_W-1:0] rsp_next_slot_ff, rsp_next_slot_in;

   logic              req_accept;
   logic              out_free;
   logic [CW-1:0]     eff_count;
   logic              eff_cr;
   logic [CW-1:0]     rx_count;
   logic              rx_cr;
   logic              rx_complete;
   logic              rx_store;
   logic              slot_last;
   logic [CW+COUNT_W-1:0] count_ext;
   logic [SLW+SLOT_W-1:0] slot_ext;

   logic              buf_wr_en;
   logic              buf_rd_en;
   logic [BYTE_W-1:0] buf_rd_data;
   logic              store_wr_en;
   logic              store_rd_en;
   logic [SW-1:0]     store_rd_addr;
   logic [BYTE_W-1:0] store_rd_data;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // A receive word after a completed line first clears all line status.
   assign eff_count = done_ff ? '0 : count_ff;
   assign eff_cr    = done_ff ? 1'b0 : cr_ff;
   assign slot_last = (slot_ff == SLW'(SLOTS - 1));

   always_comb begin
      rx_count    = eff_count;
      rx_cr       = eff_cr;
      rx_complete = 1'b0;
      rx_store    = 1'b0;
      if (eff_cr) begin
         if (req_rx_byte != CODE_LF) begin
            rx_count = '0;
            rx_cr    = 1'b0;
         end else begin
            rx_complete = 1'b1;
         end
      end else if (req_rx_byte == CODE_CR) begin
         rx_cr = 1'b1;
      end else begin
         rx_store = 1'b1;
         rx_count = (eff_count == CW'(LINE_LEN - 1)) ? '0 : eff_count + 1'b1;
      end
   end

   assign store_rd_addr = SW'(int'(req_read_slot) * LINE_LEN + int'(req_read_index));
   assign count_ext     = {{COUNT_W{1'b0}}, count_ff};
   assign slot_ext      = {{SLOT_W{1'b0}}, slot_ff};

   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      in_range_in       = in_range_ff;
      count_in          = count_ff;
      cr_in             = cr_ff;
      done_in           = done_ff;
      slot_in           = slot_ff;
      base_in           = base_ff;
      copy_base_in      = copy_base_ff;
      k_in              = k_ff;
      len_in            = len_ff;
      wr_valid_in       = wr_valid_ff;
      wr_addr_in        = wr_addr_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_read_data_in  = rsp_read_data_ff;
      rsp_line_done_in  = rsp_line_done_ff;
      rsp_cr_seen_in    = rsp_cr_seen_ff;
      rsp_byte_count_in = rsp_byte_count_ff;
      rsp_next_slot_in  = rsp_next_slot_ff;
      buf_wr_en         = 1'b0;
      buf_rd_en         = 1'b0;
      store_wr_en       = 1'b0;
      store_rd_en       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in = req_operation;
               if (req_operation == OP_READ) begin
                  store_rd_en = 1'b1;
                  in_range_in = (int'(req_read_slot) < SLOTS) &&
                                (int'(req_read_index) < LINE_LEN);
                  state_in    = ST_LOAD;
               end else begin
                  count_in  = rx_count;
                  cr_in     = rx_cr;
                  done_in   = rx_complete;
                  buf_wr_en = rx_store;
                  if (rx_complete) begin
                     len_in       = eff_count;
                     k_in         = '0;
                     wr_valid_in  = 1'b0;
                     copy_base_in = base_ff;
                     slot_in      = slot_last ? '0 : slot_ff + 1'b1;
                     base_in      = slot_last ? '0 : base_ff + SW'(LINE_LEN);
                     state_in     = ST_COPY;
                  end else begin
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_COPY: begin
            store_wr_en = wr_valid_ff;
            wr_valid_in = 1'b0;
            if (k_ff != len_ff) begin
               buf_rd_en   = 1'b1;
               k_in        = k_ff + 1'b1;
               wr_valid_in = 1'b1;
               wr_addr_in  = copy_base_ff + SW'(k_ff);
            end else if (!wr_valid_ff) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_read_data_in  = (op_ff == OP_READ && in_range_ff) ? store_rd_data : '0;
               rsp_line_done_in  = done_ff;
               rsp_cr_seen_in    = cr_ff;
               rsp_byte_count_in = count_ext[COUNT_W-1:0];
               rsp_next_slot_in  = slot_ext[SLOT_W-1:0];
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cr_ff        <= 1'b0;
         done_ff      <= 1'b0;
         slot_ff      <= '0;
         base_ff      <= '0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cr_ff        <= cr_in;
         done_ff      <= done_in;
         slot_ff      <= slot_in;
         base_ff      <= base_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff             <= op_in;
      in_range_ff       <= in_range_in;
      copy_base_ff      <= copy_base_in;
      k_ff              <= k_in;
      len_ff            <= len_in;
      wr_addr_ff        <= wr_addr_in;
      rsp_read_data_ff  <= rsp_read_data_in;
      rsp_line_done_ff  <= rsp_line_done_in;
      rsp_cr_seen_ff    <= rsp_cr_seen_in;
      rsp_byte_count_ff <= rsp_byte_count_in;
      rsp_next_slot_ff  <= rsp_next_slot_in;
   end

   crlf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LINE_LEN)
   ) u_line_buffer (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (eff_count),
      .wr_data (req_rx_byte),
      .rd_en   (buf_rd_en),
      .rd_addr (k_ff),
      .rd_data (buf_rd_data)
   );

   crlf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SLOTS * LINE_LEN)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (buf_rd_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_line_done  = rsp_line_done_ff;
   assign rsp_cr_seen    = rsp_cr_seen_ff;
   assign rsp_byte_count = rsp_byte_count_ff;
   assign rsp_next_slot  = rsp_next_slot_ff;

   // A completed line always keeps its CR status until the next receive word.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> cr_ff)
      else $error("line done without CR status");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (k_ff <= len_ff))
      else $error("copy index ran past the line length");

   assert property (@(posedge clock) disable iff (reset)
      store_wr_en |-> (state_ff == ST_COPY))
      else $error("line store written outside the copy loop");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded into the output register");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_accept && req_operation == OP_RECEIVE &&
       !(eff_cr && req_rx_byte == CODE_LF)) |=> (state_ff == ST_LOAD))
      else $error("word without a completed line entered the copy loop");

endmodule
`default_nettype wire
